/* rtl/cpfv_pkg.sv */
// ----------------------------------------------------------------------------
// cpfv_pkg
// Shared constants and types for the CPF check-digit validator.
// ----------------------------------------------------------------------------
package cpfv_pkg;

    localparam int ID_W           = 37;
    localparam int DIGITS         = 12;
    localparam int BCD_W          = 4 * DIGITS;
    localparam int BITS_PER_STAGE = 5;
    localparam int DABBLE_STAGES  = (ID_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int BIN_W          = DABBLE_STAGES * BITS_PER_STAGE;
    // input register, conversion stages, weighted sums, result register
    localparam int LATENCY        = DABBLE_STAGES + 3;

    localparam int SUM_W          = 10;

    localparam logic [ID_W-1:0] ID_LOW_BOUND  = 37'd11111111111;
    localparam logic [ID_W-1:0] ID_HIGH_BOUND = 37'd99999999999;

    typedef logic [3:0] t_digit;

endpackage

/* rtl/cpf_check_digit_validator.sv */
// ----------------------------------------------------------------------------
// cpf_check_digit_validator
// Pipelined CPF validator: range and repdigit screen, binary to BCD, and the
// two mod-11 check digits compared against the number's last two digits.
// ----------------------------------------------------------------------------
// One item can be started in every clock cycle; busy is high only while reset
// is held. The verdict appears on o_is_valid with o_done high for exactly one
// cycle. Items come out in the order they went in. The pipeline is made of an
// input register, the binary to decimal conversion, which shifts five input
// bits per stage over eight stages, one stage of weighted digit sums and one
// stage of mod-11 reduction and compare. The receiver cannot stall the block,
// so results must be captured on the cycle o_done is high.
module cpf_check_digit_validator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [cpfv_pkg::ID_W-1:0] i_id_number,
    output logic                      busy,
    output logic                      o_done,
    output logic                      o_is_valid
);
    import cpfv_pkg::*;

    localparam logic [7:0] SUB_176 = 8'd176;
    localparam logic [7:0] SUB_88  = 8'd88;
    localparam logic [7:0] SUB_44  = 8'd44;
    localparam logic [7:0] SUB_22  = 8'd22;
    localparam logic [7:0] SUB_11  = 8'd11;

    // one add-3/shift step per input bit, BITS_PER_STAGE bits per stage
    function automatic logic [BCD_W+BIN_W-1:0] dabble(
        input logic [BCD_W-1:0] bcd,
        input logic [BIN_W-1:0] bin
    );
        logic [BCD_W+BIN_W-1:0] acc;
        acc = {bcd, bin};
        for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (acc[BIN_W + 4*d +: 4] >= 4'd5) begin
                    acc[BIN_W + 4*d +: 4] = acc[BIN_W + 4*d +: 4] + 4'd3;
                end
            end
            acc = acc << 1;
        end
        return acc;
    endfunction

    // x < 1024: fold 64 = 9 (mod 11), then a subtract chain
    function automatic t_digit mod11(input logic [SUM_W-1:0] x);
        logic [7:0] y;
        y = {1'b0, x[9:6], 3'b000} + {4'b0000, x[9:6]} + {2'b00, x[5:0]};
        if (y >= SUB_176) begin
            y = y - SUB_176;
        end
        if (y >= SUB_88) begin
            y = y - SUB_88;
        end
        if (y >= SUB_44) begin
            y = y - SUB_44;
        end
        if (y >= SUB_22) begin
            y = y - SUB_22;
        end
        if (y >= SUB_11) begin
            y = y - SUB_11;
        end
        return y[3:0];
    endfunction

    function automatic t_digit check_of(input logic [SUM_W-1:0] x);
        t_digit r;
        r = mod11(x);
        return (r < 4'd2) ? 4'd0 : (4'd11 - r);
    endfunction

    // conversion pipeline, stage 0 is the input register
    logic [BIN_W-1:0] r_bin     [DABBLE_STAGES+1];
    logic [BCD_W-1:0] r_bcd     [DABBLE_STAGES+1];
    logic             r_inrange [DABBLE_STAGES+1];
    logic             r_vld     [DABBLE_STAGES+1];
    logic [BIN_W-1:0] n_bin     [DABBLE_STAGES];
    logic [BCD_W-1:0] n_bcd     [DABBLE_STAGES];

    // sums stage
    logic             r_s_vld;
    logic             r_pre;
    logic [SUM_W-1:0] r_sum1;
    logic [SUM_W-1:0] r_sum2;
    t_digit           r_cd1;
    t_digit           r_cd0;
    logic [SUM_W-1:0] n_sum1;
    logic [SUM_W-1:0] n_sum2;
    logic             n_rep;
    t_digit           dig [DIGITS];

    logic             n_pass;
    logic             accept;

    assign busy   = ~i_rst_n;
    assign accept = start && !busy;

    always_comb begin
        for (int s = 0; s < DABBLE_STAGES; s++) begin
            {n_bcd[s], n_bin[s]} = dabble(r_bcd[s], r_bin[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DABBLE_STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= accept;
            for (int s = 0; s < DABBLE_STAGES; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin[0]     <= {{(BIN_W-ID_W){1'b0}}, i_id_number};
        r_bcd[0]     <= '0;
        r_inrange[0] <= (i_id_number >= ID_LOW_BOUND) && (i_id_number <= ID_HIGH_BOUND);
        for (int s = 0; s < DABBLE_STAGES; s++) begin
            r_bin[s+1]     <= n_bin[s];
            r_bcd[s+1]     <= n_bcd[s];
            r_inrange[s+1] <= r_inrange[s];
        end
    end

    always_comb begin
        for (int j = 0; j < DIGITS; j++) begin
            dig[j] = r_bcd[DABBLE_STAGES][4*j +: 4];
        end
        n_sum1 = '0;
        n_sum2 = '0;
        n_rep  = 1'b1;
        // first check digit: digits 2..10 weighted 2..10
        for (int j = 2; j <= 10; j++) begin
            n_sum1 = n_sum1 + {{(SUM_W-4){1'b0}}, dig[j]} * SUM_W'(j);
        end
        // second check digit: digits 1..10 weighted 2..11
        for (int j = 1; j <= 10; j++) begin
            n_sum2 = n_sum2 + {{(SUM_W-4){1'b0}}, dig[j]} * SUM_W'(j + 1);
        end
        // in range, so a multiple of 11111111111 is exactly a repdigit
        for (int j = 0; j < 10; j++) begin
            if (dig[j] != dig[10]) begin
                n_rep = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else begin
            r_s_vld <= r_vld[DABBLE_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre  <= r_inrange[DABBLE_STAGES] && !n_rep;
        r_sum1 <= n_sum1;
        r_sum2 <= n_sum2;
        r_cd1  <= dig[1];
        r_cd0  <= dig[0];
    end

    assign n_pass = r_pre && (check_of(r_sum1) == r_cd1) && (check_of(r_sum2) == r_cd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done     <= 1'b0;
            o_is_valid <= 1'b0;
        end else begin
            o_done     <= r_s_vld;
            o_is_valid <= r_s_vld && n_pass;
        end
    end

    // every accepted item comes out with its own o_done strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("item did not complete after pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching accepted item");

    a_valid_qualified: assert property (@(posedge i_clk)
        o_is_valid |-> o_done)
        else $error("is_valid raised outside a result cycle");

endmodule
